/* design/ill_pkg.sv */
// Shared types and constants for the indexed linked list engine.
`default_nettype none
package ill_pkg;

  localparam int unsigned PTR_W = 6;
  localparam logic [PTR_W-1:0] NULL_PTR = 6'h3F;

  typedef enum logic [1:0] {
    CMD_INS_HEAD = 2'd0,
    CMD_INS_TAIL = 2'd1,
    CMD_READOUT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic               last;
  } out_req_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    rd_free;
    logic    rd_head;
    logic    rd_next;
    logic    alloc;
    logic    alloc_head;
    logic    link_tail;
    logic    emit;
    logic    emit_node;
    status_e emit_status;
  } ill_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic free_empty;
    logic list_empty;
    logic out_free;
    logic walk_last;
  } ill_sts_t;

endpackage
`default_nettype wire

/* design/ill_ctrl.sv */
// Control state machine for the indexed linked list engine.
`default_nettype none
module ill_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [1:0]      cmd_i,
  input  wire ill_pkg::ill_sts_t sts_i,
  output ill_pkg::ill_cmd_t    cmd_o
);
  import ill_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_LINK,
    S_RESP,
    S_WALK
  } state_e;

  state_e  state_q, state_d;
  logic    at_head_q, at_head_d;
  status_e resp_q, resp_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o     = '0;
    cmd_o.emit_status = ST_OK;
    state_d   = state_q;
    at_head_d = at_head_q;
    resp_d    = resp_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_e'(cmd_i))
            CMD_INS_HEAD, CMD_INS_TAIL: begin
              cmd_o.capture = 1'b1;
              if (sts_i.free_empty) begin
                if (sts_i.out_free) begin
                  cmd_o.emit        = 1'b1;
                  cmd_o.emit_status = ST_FULL;
                end else begin
                  resp_d  = ST_FULL;
                  state_d = S_RESP;
                end
              end else begin
                cmd_o.rd_free = 1'b1;
                at_head_d     = (cmd_e'(cmd_i) == CMD_INS_HEAD);
                state_d       = S_ALLOC;
              end
            end
            CMD_READOUT: begin
              if (sts_i.list_empty) begin
                if (sts_i.out_free) begin
                  cmd_o.emit        = 1'b1;
                  cmd_o.emit_status = ST_EMPTY;
                end else begin
                  resp_d  = ST_EMPTY;
                  state_d = S_RESP;
                end
              end else begin
                cmd_o.rd_head = 1'b1;
                state_d       = S_WALK;
              end
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      S_ALLOC: begin
        cmd_o.alloc      = 1'b1;
        cmd_o.alloc_head = at_head_q;
        resp_d           = ST_OK;
        if (!at_head_q && !sts_i.list_empty) begin
          state_d = S_LINK;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_RESP;
        end
      end
      S_LINK: begin
        cmd_o.link_tail = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = resp_q;
          state_d           = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_node = 1'b1;
          if (sts_i.walk_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      at_head_q <= 1'b0;
      resp_q    <= ST_OK;
    end else begin
      state_q   <= state_d;
      at_head_q <= at_head_d;
      resp_q    <= resp_d;
    end
  end

endmodule
`default_nettype wire

/* design/ill_datapath.sv */
// Node store, list pointers and result register of the linked list engine.
`default_nettype none
module ill_datapath #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic signed [31:0]  value_i,
  input  wire ill_pkg::ill_cmd_t   cmd_i,
  output ill_pkg::ill_sts_t        sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ill_pkg::out_req_t        out_req_o
);
  import ill_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [PTR_W-1:0] CAP_P  = PTR_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_N = IDX_W'(CAPACITY - 1);

  logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic [PTR_W-1:0]      link_mem [CAPACITY];
  logic [CAPACITY-1:0]   link_vld_q;

  logic [DATA_WIDTH-1:0] val_q;       // value captured at accept
  logic [DATA_WIDTH-1:0] val_in;
  logic [DATA_WIDTH-1:0] val_rd_q;
  logic [PTR_W-1:0]      link_rd_q;
  logic [PTR_W-1:0]      head_q, free_q, tail_q, slot_q;
  logic [IDX_W-1:0]      cnt_q;
  logic [31:0]           val_wide;

  logic                  out_vld_q;
  out_req_t              out_q;

  logic                  rd_en;
  logic [PTR_W-1:0]      rd_ptr;
  logic [IDX_W-1:0]      rd_idx;
  logic [PTR_W-1:0]      rd_rst_link;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [PTR_W-1:0]      wr_link;
  logic                  nxt_null;

  function automatic logic is_null(input logic [PTR_W-1:0] p);
    return p >= CAP_P;
  endfunction

  // Width adaption in and out of the store
  if (DATA_WIDTH <= 32) begin : g_narrow
    assign val_in = value_i[DATA_WIDTH-1:0];
    if (DATA_WIDTH == 32) begin : g_eq
      assign val_wide = val_rd_q;
    end else begin : g_sx
      assign val_wide = {{(32-DATA_WIDTH){val_rd_q[DATA_WIDTH-1]}}, val_rd_q};
    end
  end else begin : g_wide
    assign val_in   = {{(DATA_WIDTH-32){1'b0}}, value_i};
    assign val_wide = val_rd_q[31:0];
  end

  // Read port
  assign rd_en  = cmd_i.rd_free | cmd_i.rd_head | cmd_i.rd_next;
  always_comb begin
    priority if (cmd_i.rd_free) begin
      rd_ptr = free_q;
    end else if (cmd_i.rd_head) begin
      rd_ptr = head_q;
    end else begin
      rd_ptr = link_rd_q;
    end
  end
  assign rd_idx      = rd_ptr[IDX_W-1:0];
  assign rd_rst_link = is_null(PTR_W'(rd_idx) + PTR_W'(1)) ? NULL_PTR
                                                            : PTR_W'(rd_idx) + PTR_W'(1);

  // Write port of the link store: new node, or old tail relinked
  assign wr_en   = cmd_i.alloc | cmd_i.link_tail;
  assign wr_idx  = cmd_i.alloc ? free_q[IDX_W-1:0] : tail_q[IDX_W-1:0];
  always_comb begin
    priority if (cmd_i.link_tail) begin
      wr_link = slot_q;
    end else if (cmd_i.alloc_head && !is_null(head_q)) begin
      wr_link = head_q;
    end else begin
      wr_link = NULL_PTR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_idx] <= wr_link;
    end
    if (cmd_i.alloc) begin
      val_mem[free_q[IDX_W-1:0]] <= val_q;
    end
    if (rd_en) begin
      link_rd_q <= link_vld_q[rd_idx] ? link_mem[rd_idx] : rd_rst_link;
      val_rd_q  <= val_mem[rd_idx];
    end
    if (cmd_i.capture) begin
      val_q <= val_in;
    end
    if (cmd_i.alloc) begin
      slot_q <= free_q;
    end
    if (cmd_i.rd_head) begin
      cnt_q <= '0;
    end else if (cmd_i.rd_next) begin
      cnt_q <= cnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      head_q     <= NULL_PTR;
      free_q     <= '0;
      tail_q     <= NULL_PTR;
    end else begin
      if (wr_en) begin
        link_vld_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.alloc) begin
        free_q <= is_null(link_rd_q) ? NULL_PTR : link_rd_q;
        if (cmd_i.alloc_head || is_null(head_q)) begin
          head_q <= free_q;
        end
        if (is_null(head_q)) begin
          tail_q <= free_q;
        end
      end
      if (cmd_i.link_tail) begin
        tail_q <= slot_q;
      end
    end
  end

  // Result register
  assign nxt_null = is_null(link_rd_q) || (cnt_q == LAST_N);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.emit_node) begin
        out_q.status     <= ST_OK;
        out_q.item_value <= val_wide;
        out_q.last       <= nxt_null;
      end else begin
        out_q.status     <= cmd_i.emit_status;
        out_q.item_value <= '0;
        out_q.last       <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_req_o        = out_q;
  assign sts_o.free_empty = is_null(free_q);
  assign sts_o.list_empty = is_null(head_q);
  assign sts_o.out_free   = !out_vld_q || !out_stall_i;
  assign sts_o.walk_last  = nxt_null;

endmodule
`default_nettype wire

/* design/indexed_linked_list_engine.sv */
// Top level of the indexed linked list engine.
// A singly linked list of up to CAPACITY values kept in an on-chip node store,
// with unused entries threaded on a free list.
// Input channel (in_valid_i / in_stall_o / in_req_i): one request carries a
//   command and a value. Insert at head, insert at tail, or read out the list.
//   Command code 3 is accepted and dropped without a result.
// Output channel (out_valid_o / out_stall_i / out_req_o): each insert gives one
//   result (ok or full). A readout gives one result per node, head first, with
//   last set on the tail node; an empty list gives a single empty result.
// Sequence: insert at head or onto an empty list goes through an alloc state,
//   insert at tail through alloc and link states (a tail pointer is kept, so no
//   walk). Readout reads the head node, then gives the nodes in turn: the link
//   read of one node gives the address of the next.
// The next request is taken once the previous one has issued its last result
//   into the output register, even if that result still waits to be taken.
// A stalled receiver holds the output register and freezes the walk.
// Reset: list empty, all entries free in index order; no clearing pass.
`default_nettype none
module indexed_linked_list_engine #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ill_pkg::in_req_t   in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ill_pkg::out_req_t       out_req_o
);
  import ill_pkg::*;

  ill_cmd_t dp_cmd;   // controller commands
  ill_sts_t dp_sts;   // datapath status

  ill_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (in_req_i.command),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  ill_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_req_i.value),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_indexed_linked_list_engine.sv */
// Testbench for the indexed linked list engine: random-stall driver, monitor and list predictor.
`timescale 1ns / 1ps
module tb_indexed_linked_list_engine;
  import ill_pkg::*;

  localparam int unsigned CAP          = 32;
  localparam int unsigned DW           = 32;
  localparam int unsigned IDX_W        = $clog2(CAP);
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_REQS  = 318;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;

  // requests waiting to be sent, and results the list should give back
  in_req_t  pending_reqs[$];
  out_req_t expected_results[$];

  // shadow copy of the node store, list head and free list
  logic signed [31:0] node_val[CAP];
  logic [PTR_W-1:0]   node_link[CAP];
  logic [PTR_W-1:0]   head_ptr;
  logic [PTR_W-1:0]   free_ptr;

  bit          running = 1'b0;
  bit          in_fire = 1'b0;
  int unsigned cyc     = 0;
  int unsigned err_cnt = 0;
  logic        calm;

  // one stretch of the run with no idling on either side
  assign calm = (cyc >= 1500) && (cyc < 2600);

  always #6 clk = ~clk;

  indexed_linked_list_engine #(
    .CAPACITY   (CAP),
    .DATA_WIDTH (DW)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void queue_req(logic [1:0] cmd, logic signed [31:0] v);
    in_req_t r;
    r.command = cmd;
    r.value   = v;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_result(status_e st, logic signed [31:0] v, logic lst);
    out_req_t o;
    o.status     = st;
    o.item_value = v;
    o.last       = lst;
    expected_results.push_back(o);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Applies one accepted request to the shadow list and queues its results.
  function automatic void apply_list_cmd(in_req_t req);
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] nxt;
    int               n;
    case (req.command)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (free_ptr >= CAP) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          slot     = free_ptr;
          free_ptr = (node_link[slot[IDX_W-1:0]] >= CAP) ? NULL_PTR
                                                         : node_link[slot[IDX_W-1:0]];
          node_val[slot[IDX_W-1:0]] = req.value;
          if (req.command == CMD_INS_HEAD) begin
            node_link[slot[IDX_W-1:0]] = (head_ptr >= CAP) ? NULL_PTR : head_ptr;
            head_ptr                   = slot;
          end else begin
            node_link[slot[IDX_W-1:0]] = NULL_PTR;
            if (head_ptr >= CAP) begin
              head_ptr = slot;
            end else begin
              // walk to the tail, bounded by the store size
              cur = head_ptr;
              n   = 0;
              while (node_link[cur[IDX_W-1:0]] < CAP && n < CAP) begin
                cur = node_link[cur[IDX_W-1:0]];
                n++;
              end
              node_link[cur[IDX_W-1:0]] = slot;
            end
          end
          push_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_READOUT: begin
        if (head_ptr >= CAP) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          cur = head_ptr;
          n   = 0;
          while (cur < CAP && n < CAP) begin
            nxt = node_link[cur[IDX_W-1:0]];
            push_result(ST_OK, node_val[cur[IDX_W-1:0]], (nxt >= CAP) || (n + 1 >= CAP));
            n++;
            cur = nxt;
          end
        end
      end
      default: ;  // unused code: dropped, no result
    endcase
  endfunction

  // acceptance of a request: update the shadow list right at the edge
  always @(posedge clk) begin
    if (rst_n && running && in_valid && !in_stall) begin
      apply_list_cmd(in_req);
      in_fire = 1'b1;
    end
  end

  // driver: a presented request holds until taken, then the next one or a gap
  always @(negedge clk) begin
    if (running && (!in_valid || in_fire)) begin
      in_fire = 1'b0;
      if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
        in_valid <= 1'b1;
        in_req   <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (running) begin
      out_stall <= !calm && ($urandom_range(99) < 30);
    end
  end

  // monitor: every taken result against the oldest expectation
  always @(posedge clk) begin : result_check
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                  out_req.status, out_req.item_value, out_req.last));
      end else begin
        want = expected_results.pop_front();
        if (out_req.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_req.status, want.status));
        if (out_req.item_value !== want.item_value)
          report_mismatch($sformatf("item_value got %0d want %0d",
                                    out_req.item_value, want.item_value));
        if (out_req.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_req.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int          r;
    logic [1:0]  cmd;
    for (int i = 0; i < CAP; i++) begin
      node_val[IDX_W'(i)]  = '0;
      node_link[IDX_W'(i)] = (i + 1 < CAP) ? PTR_W'(i + 1) : NULL_PTR;
    end
    head_ptr = NULL_PTR;
    free_ptr = '0;

    // directed: empty readout, dropped code, extremes at both ends
    queue_req(CMD_READOUT, 32'h0000_0000);
    queue_req(CMD_UNUSED,  32'h1234_5678);
    queue_req(CMD_INS_TAIL, 32'h7FFF_FFFF);
    queue_req(CMD_READOUT, 32'hFFFF_FFFF);
    queue_req(CMD_INS_HEAD, 32'h8000_0000);
    queue_req(CMD_INS_TAIL, 32'h0000_0000);
    queue_req(CMD_INS_HEAD, 32'hFFFF_FFFF);
    queue_req(CMD_INS_TAIL, 32'h5555_5555);
    queue_req(CMD_INS_HEAD, 32'hAAAA_AAAA);
    queue_req(CMD_READOUT, 32'h8000_0000);
    queue_req(CMD_UNUSED,  32'hFFFF_FFFF);
    queue_req(CMD_READOUT, 32'h7FFF_FFFF);

    // random mix: fills the store, then full refusals and full-depth readouts
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(99);
      if (r < 3)       cmd = CMD_UNUSED;
      else if (r < 18) cmd = CMD_READOUT;
      else if (r < 59) cmd = CMD_INS_HEAD;
      else             cmd = CMD_INS_TAIL;
      queue_req(cmd, pick_value());
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n   = 1'b1;
    running = 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
